@@ rtl/lfq_pkg.sv @@
package lfq_pkg;

    localparam int DEPTH_DEF       = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    // command codes
    localparam logic [2:0] CMD_ENQ   = 3'd0;
    localparam logic [2:0] CMD_DEQ   = 3'd1;
    localparam logic [2:0] CMD_RM    = 3'd2;
    localparam logic [2:0] CMD_FIND  = 3'd3;
    localparam logic [2:0] CMD_CLEAR = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] value;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] result_value;
        logic [3:0]  position;
        logic [4:0]  count;
        logic        is_empty;
    } t_out_word;

endpackage

@@ rtl/lfq_mem.sv @@
module lfq_mem
    import lfq_pkg::*;
#(
    parameter int WIDTH = VALUE_WIDTH_DEF,
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/linked_fifo_with_remove_top.sv @@
// Linked-list queue of up to DEPTH values with enqueue, dequeue, remove-by-value,
// find-by-value and clear.
// Input channel: i_in_valid / o_in_stall carry one command word (cmd, value).
// Output channel: o_out_valid / i_out_stall carry one result word per command
// (status, result_value, position, count, is_empty).
// One command is worked at a time; o_in_stall is high from acceptance until
// its result is loaded into the output register.
// Enqueue passes through dispatch and, when a freed slot is reused, a pop of
// the free chain; dequeue reads the head and then frees its slot; find and
// remove walk the list, and a remove that hits also frees the slot. The walk
// reads one entry per cycle from the value and link memories through their
// single read port.
// The next command can be taken in the cycle after the result is loaded.
// A result waiting under i_out_stall does not block a new command; that
// command is worked and holds in its final step until the output is free.
// Reset empties the queue and the output register; no clearing pass is run.
// Freed slots are chained through the link memory, so memory contents are
// never cleared.
module linked_fifo_with_remove_top
    import lfq_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_ENQ_POP  = 3'd2;
    localparam logic [2:0] S_DEQ      = 3'd3;
    localparam logic [2:0] S_WALK     = 3'd4;
    localparam logic [2:0] S_FREE     = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    logic [2:0]    r_state, n_state;
    logic [2:0]    r_cmd, n_cmd;
    logic [SW-1:0] r_val, n_val;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_fresh, n_fresh;     // slots handed out since clear
    logic [AW-1:0] r_free_head, n_free_head;
    logic [AW-1:0] r_cur, n_cur;
    logic [AW-1:0] r_prev, n_prev;
    logic [AW-1:0] r_idx, n_idx;
    t_out_word     r_res, n_res;
    logic          r_out_valid, n_out_valid;
    t_out_word     r_out_word, n_out_word;

    logic          val_we;
    logic [AW-1:0] val_waddr;
    logic          link_we;
    logic [AW-1:0] link_waddr;
    logic [AW-1:0] link_wdata;
    logic [AW-1:0] mem_raddr;
    logic [SW-1:0] val_rdata;
    logic [AW-1:0] link_rdata;
    logic          do_enq;
    logic [AW-1:0] enq_slot;
    logic          free_avail;

    lfq_mem #(.WIDTH(SW), .DEPTH(DEPTH)) u_val_mem (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (val_waddr),
        .i_wdata (r_val),
        .i_raddr (mem_raddr),
        .o_rdata (val_rdata)
    );

    lfq_mem #(.WIDTH(AW), .DEPTH(DEPTH)) u_link_mem (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (link_rdata)
    );

    // freed slots sit on the free chain; never-used slots come from r_fresh
    assign free_avail = (r_fresh != r_count);

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_val       = r_val;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_fresh     = r_fresh;
        n_free_head = r_free_head;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_idx       = r_idx;
        n_res       = r_res;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_word  = r_out_word;
        val_we      = 1'b0;
        val_waddr   = r_tail;
        link_we     = 1'b0;
        link_waddr  = r_tail;
        link_wdata  = r_free_head;
        mem_raddr   = r_head;
        do_enq      = 1'b0;
        enq_slot    = r_free_head;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = i_in_word.cmd;
                    n_val   = i_in_word.value[SW-1:0];
                    n_res   = '0;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_state = S_DONE;
                case (r_cmd)
                    CMD_ENQ: begin
                        if (r_count == CW'(DEPTH)) begin
                            n_res.status = ST_FULL;
                        end else if (free_avail) begin
                            mem_raddr = r_free_head;
                            n_state   = S_ENQ_POP;
                        end else begin
                            do_enq   = 1'b1;
                            enq_slot = r_fresh[AW-1:0];
                            n_fresh  = r_fresh + CW'(1);
                        end
                    end
                    CMD_DEQ: begin
                        if (r_count == '0) begin
                            n_res.status = ST_EMPTY;
                        end else begin
                            mem_raddr = r_head;
                            n_state   = S_DEQ;
                        end
                    end
                    CMD_RM, CMD_FIND: begin
                        if (r_count == '0) begin
                            n_res.status = ST_EMPTY;
                        end else begin
                            mem_raddr = r_head;
                            n_cur     = r_head;
                            n_prev    = r_head;
                            n_idx     = '0;
                            n_state   = S_WALK;
                        end
                    end
                    CMD_CLEAR: begin
                        n_count = '0;
                        n_fresh = '0;
                        n_head  = '0;
                        n_tail  = '0;
                    end
                    default: begin
                    end
                endcase
            end
            S_ENQ_POP: begin
                do_enq      = 1'b1;
                enq_slot    = r_free_head;
                n_free_head = link_rdata;
                n_state     = S_DONE;
            end
            S_DEQ: begin
                n_res.result_value = 32'(val_rdata);
                n_count = r_count - CW'(1);
                if (r_count != CW'(1)) begin
                    n_head = link_rdata;
                end
                n_cur   = r_head;
                n_state = S_FREE;
            end
            S_WALK: begin
                if (val_rdata == r_val) begin
                    n_res.position = 4'(r_idx);
                    if (r_cmd == CMD_FIND) begin
                        n_res.result_value = 32'(r_val);
                        n_state = S_DONE;
                    end else begin
                        if (r_idx == '0) begin
                            n_head = link_rdata;
                        end else begin
                            link_we    = 1'b1;
                            link_waddr = r_prev;
                            link_wdata = link_rdata;
                            if (r_cur == r_tail) begin
                                n_tail = r_prev;
                            end
                        end
                        n_count = r_count - CW'(1);
                        n_state = S_FREE;
                    end
                end else if (CW'(r_idx) + CW'(1) == r_count) begin
                    n_res.status = ST_NOT_FOUND;
                    n_state = S_DONE;
                end else begin
                    mem_raddr = link_rdata;
                    n_prev    = r_cur;
                    n_cur     = link_rdata;
                    n_idx     = r_idx + AW'(1);
                end
            end
            S_FREE: begin
                // push the dropped slot onto the free chain
                link_we     = 1'b1;
                link_waddr  = r_cur;
                link_wdata  = r_free_head;
                n_free_head = r_cur;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid         = 1'b1;
                    n_out_word          = r_res;
                    n_out_word.count    = 5'(r_count);
                    n_out_word.is_empty = (r_count == '0);
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (do_enq) begin
            val_we    = 1'b1;
            val_waddr = enq_slot;
            if (r_count == '0) begin
                n_head = enq_slot;
            end else begin
                link_we    = 1'b1;
                link_waddr = r_tail;
                link_wdata = enq_slot;
            end
            n_tail  = enq_slot;
            n_count = r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_fresh     <= '0;
            r_free_head <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_fresh     <= n_fresh;
            r_free_head <= n_free_head;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_val      <= n_val;
        r_cur      <= n_cur;
        r_prev     <= n_prev;
        r_idx      <= n_idx;
        r_res      <= n_res;
        r_out_word <= n_out_word;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

@@ dv/tb_linked_fifo_with_remove_top.sv @@
module tb_linked_fifo_with_remove_top;
    import lfq_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RAND_BLOCKS = 13;
    localparam int BLOCK_ITEMS = 100;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_word  in_word = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_word out_word;

    linked_fifo_with_remove_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    always #10 i_clk = ~i_clk;

    // queue shadow, slot for slot
    logic [31:0] slot_val  [DEPTH];
    logic [3:0]  slot_next [DEPTH];
    bit          slot_live [DEPTH];
    logic [3:0]  head_idx = '0;
    logic [3:0]  tail_idx = '0;
    logic [4:0]  n_live = '0;

    t_out_word pending_results[$];
    int        n_errors = 0;
    int        cycle_cnt = 0;
    bit        calm = 1'b0;
    int        stall_run = 0;

    typedef struct {
        logic [2:0]  cmd;
        logic [31:0] value;
        int          reps;
        bit          typed;
        t_out_word   res;
    } t_dir_row;

    t_dir_row dir_rows[$];

    initial begin
        for (int s = 0; s < DEPTH; s++) begin
            slot_live[s] = 1'b0;
            slot_val[s]  = '0;
            slot_next[s] = '0;
        end
    end

    // result word of one command, updates the shadow queue
    function automatic t_out_word run_queue_cmd(t_in_word w);
        t_out_word  r;
        logic [3:0] cur, prv, fr;
        bit         found, hit;
        int         s, k;
        r = '0;
        r.status = ST_OK;
        fr = '0;
        case (w.cmd)
            CMD_ENQ: begin
                if (n_live >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    found = 1'b0;
                    for (s = 0; s < DEPTH; s++) begin
                        if (!found && !slot_live[s]) begin
                            found = 1'b1;
                            fr = 4'(s);
                        end
                    end
                    slot_val[fr]  = w.value;
                    slot_next[fr] = '0;
                    slot_live[fr] = 1'b1;
                    if (n_live == 0)
                        head_idx = fr;
                    else
                        slot_next[tail_idx] = fr;
                    tail_idx = fr;
                    n_live++;
                end
            end
            CMD_DEQ: begin
                if (n_live == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.result_value = slot_val[head_idx];
                    slot_live[head_idx] = 1'b0;
                    n_live--;
                    if (n_live != 0)
                        head_idx = slot_next[head_idx];
                end
            end
            CMD_RM, CMD_FIND: begin
                if (n_live == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    cur = head_idx;
                    prv = cur;
                    hit = 1'b0;
                    for (k = 0; k < n_live && !hit; k++) begin
                        if (slot_val[cur] == w.value) begin
                            hit = 1'b1;
                            r.position = 4'(k);
                            if (w.cmd == CMD_FIND) begin
                                r.result_value = w.value;
                            end else begin
                                if (k == 0) begin
                                    head_idx = slot_next[cur];
                                end else begin
                                    slot_next[prv] = slot_next[cur];
                                    if (cur == tail_idx)
                                        tail_idx = prv;
                                end
                                slot_live[cur] = 1'b0;
                                n_live--;
                            end
                        end else begin
                            prv = cur;
                            cur = slot_next[cur];
                        end
                    end
                    if (!hit)
                        r.status = ST_NOT_FOUND;
                end
            end
            CMD_CLEAR: begin
                for (s = 0; s < DEPTH; s++)
                    slot_live[s] = 1'b0;
                n_live   = '0;
                head_idx = '0;
                tail_idx = '0;
            end
            default: ;
        endcase
        r.count    = n_live;
        r.is_empty = (n_live == 0);
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // mostly values that are live in the queue or collide often
    function automatic logic [31:0] pick_value();
        int         r, steps;
        logic [3:0] cur;
        r = $urandom_range(0, 99);
        if (r < 45 && n_live != 0) begin
            cur = head_idx;
            steps = $urandom_range(0, int'(n_live) - 1);
            repeat (steps) cur = slot_next[cur];
            return slot_val[cur];
        end
        if (r < 70) return 32'($urandom_range(0, 7));
        if (r < 75) return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
        return $urandom;
    endfunction

    function automatic logic [2:0] pick_cmd(bit filling);
        int r;
        r = $urandom_range(0, 99);
        if (filling) begin
            if (r < 45) return CMD_ENQ;
            if (r < 57) return CMD_DEQ;
            if (r < 72) return CMD_RM;
            if (r < 94) return CMD_FIND;
        end else begin
            if (r < 20) return CMD_ENQ;
            if (r < 55) return CMD_DEQ;
            if (r < 75) return CMD_RM;
            if (r < 94) return CMD_FIND;
        end
        if (r < 95) return CMD_CLEAR;
        return 3'($urandom_range(5, 7));
    endfunction

    function automatic void add_row(logic [2:0] c, logic [31:0] v, int reps, bit typed,
                                    logic [1:0] st, logic [4:0] cnt);
        t_dir_row row;
        row.cmd   = c;
        row.value = v;
        row.reps  = reps;
        row.typed = typed;
        row.res   = '0;
        row.res.status   = st;
        row.res.count    = cnt;
        row.res.is_empty = (cnt == 0);
        dir_rows.push_back(row);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        $display("mismatch %s: expected %0h got %0h (cycle %0d)", what, want, got, cycle_cnt);
        n_errors++;
    endtask

    // present one word, hold it until taken, then log its expected result
    task automatic send_cmd(logic [2:0] c, logic [31:0] v, bit typed, t_out_word typed_res);
        int        gap;
        t_in_word  w;
        t_out_word pred;
        w.cmd   = c;
        w.value = v;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge i_clk); while (in_stall);
        pred = run_queue_cmd(w);
        pending_results.push_back(typed ? typed_res : pred);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // receiver: check taken words, random stall runs
    always @(posedge i_clk) begin
        t_out_word want;
        int        r;
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word", '0, out_word.result_value);
            end else begin
                want = pending_results.pop_front();
                if (out_word.status !== want.status)
                    report_mismatch("status", 32'(want.status), 32'(out_word.status));
                if (out_word.result_value !== want.result_value)
                    report_mismatch("result_value", want.result_value, out_word.result_value);
                if (out_word.position !== want.position)
                    report_mismatch("position", 32'(want.position), 32'(out_word.position));
                if (out_word.count !== want.count)
                    report_mismatch("count", 32'(want.count), 32'(out_word.count));
                if (out_word.is_empty !== want.is_empty)
                    report_mismatch("is_empty", 32'(want.is_empty), 32'(out_word.is_empty));
            end
        end
        if (stall_run > 0) begin
            stall_run--;
            out_stall <= 1'b1;
        end else if (calm) begin
            out_stall <= 1'b0;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                out_stall <= 1'b0;
            end else if (r < 95) begin
                stall_run = $urandom_range(0, 2);
                out_stall <= 1'b1;
            end else begin
                stall_run = $urandom_range(14, 49);
                out_stall <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int        k, blk, n;
        bit        filling;
        t_dir_row  row;

        // empty queue, unknown code, fill to full with duplicates, then
        // remove from head, middle and tail, then refill, find, miss a remove and clear
        add_row(CMD_DEQ,   32'h0,         1,  1'b1, ST_EMPTY,     5'd0);
        add_row(CMD_FIND,  32'h5,         1,  1'b1, ST_EMPTY,     5'd0);
        add_row(CMD_RM,    32'h5,         1,  1'b1, ST_EMPTY,     5'd0);
        add_row(3'd7,      32'hFFFF_FFFF, 1,  1'b1, ST_OK,        5'd0);
        add_row(CMD_ENQ,   32'h0,         1,  1'b1, ST_OK,        5'd1);
        add_row(CMD_ENQ,   32'hFFFF_FFFF, 1,  1'b1, ST_OK,        5'd2);
        add_row(CMD_ENQ,   32'h0,         1,  1'b0, ST_OK,        5'd0);
        add_row(CMD_ENQ,   32'h10,        13, 1'b0, ST_OK,        5'd0);
        add_row(CMD_ENQ,   32'h1,         1,  1'b1, ST_FULL,      5'd16);
        add_row(CMD_FIND,  32'h0,         1,  1'b0, ST_OK,        5'd0);
        add_row(CMD_RM,    32'hFFFF_FFFF, 1,  1'b0, ST_OK,        5'd0);
        add_row(CMD_RM,    32'h0,         1,  1'b0, ST_OK,        5'd0);
        add_row(CMD_RM,    32'h1C,        1,  1'b0, ST_OK,        5'd0);
        add_row(CMD_ENQ,   32'h7FFF_FFFF, 1,  1'b0, ST_OK,        5'd0);
        add_row(CMD_FIND,  32'h7FFF_FFFF, 1,  1'b0, ST_OK,        5'd0);
        add_row(CMD_RM,    32'h99,        1,  1'b1, ST_NOT_FOUND, 5'd14);
        add_row(CMD_CLEAR, 32'h0,         1,  1'b1, ST_OK,        5'd0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            for (k = 0; k < row.reps; k++)
                send_cmd(row.cmd, row.value + 32'(k), row.typed, row.res);
        end

        for (blk = 0; blk < RAND_BLOCKS; blk++) begin
            filling = (blk % 2 == 0);
            calm    = ($urandom_range(0, 3) == 0);
            n = BLOCK_ITEMS + $urandom_range(0, 20) - 10;
            for (k = 0; k < n; k++)
                send_cmd(pick_cmd(filling), pick_value(), 1'b0, '0);
            // hold off until the block has caught up once mid-run
            if (blk == RAND_BLOCKS / 2)
                wait_drained();
        end
        calm = 1'b0;

        wait_drained();
        repeat (64) @(posedge i_clk);
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/lfq_pkg.sv
rtl/lfq_mem.sv
rtl/linked_fifo_with_remove_top.sv
dv/tb_linked_fifo_with_remove_top.sv
